// ----- src/simple_risc_instruction_execute_macros.svh -----
// Assertion macros shared by the instruction execute block.
`ifndef SIMPLE_RISC_INSTRUCTION_EXECUTE_MACROS_SVH
`define SIMPLE_RISC_INSTRUCTION_EXECUTE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge outside reset.
`define SRIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srie: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SRIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srie: next-cycle check failed");

`else

`define SRIE_ASSERT_NOW(label, ante, cons)
`define SRIE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/srie_pkg.sv -----
// Types and constants of the instruction execute block.
package srie_pkg;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_LSF = 5'd2;
  localparam logic [4:0] OP_RSF = 5'd3;
  localparam logic [4:0] OP_AND = 5'd4;
  localparam logic [4:0] OP_OR  = 5'd5;
  localparam logic [4:0] OP_XOR = 5'd6;
  localparam logic [4:0] OP_LHI = 5'd7;
  localparam logic [4:0] OP_LD  = 5'd8;
  localparam logic [4:0] OP_ST  = 5'd9;
  localparam logic [4:0] OP_JLT = 5'd16;
  localparam logic [4:0] OP_JLE = 5'd17;
  localparam logic [4:0] OP_JEQ = 5'd18;
  localparam logic [4:0] OP_JNE = 5'd19;
  localparam logic [4:0] OP_JIN = 5'd20;
  localparam logic [4:0] OP_HLT = 5'd24;

  localparam logic [2:0] IMM_SEL  = 3'd1;
  localparam logic [2:0] LINK_REG = 3'd7;

  localparam int NUM_REGS = 8;

  typedef struct packed {
    logic signed [15:0] immediate;
    logic [2:0]         source_b_reg;
    logic [2:0]         source_a_reg;
    logic [2:0]         dest_reg;
    logic [4:0]         opcode;
  } instr_t;

  typedef struct packed {
    logic [15:0] npc;
    logic [31:0] a;
    logic [31:0] b;
    logic        halted;
    logic        wr_en;
    logic [2:0]  wr_addr;
    logic [31:0] wr_data;
    logic        mem_we;
    logic        mem_re;
    logic        ld_wb;
  } exec_res_t;

  typedef struct packed {
    logic we;
    logic re;
  } dmem_cmd_t;

endpackage

// ----- src/srie_exec.sv -----
// Execute logic: operand select, ALU, branch decision and writeback selection.
module srie_exec #(
  parameter int MEM_WORDS = 4096
) (
  input  srie_pkg::instr_t    ins,
  input  logic [31:0]         rd_a,
  input  logic [31:0]         rd_b,
  input  logic [15:0]         pc,
  output srie_pkg::exec_res_t res
);

  localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

  logic [31:0] imm32;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] alu;
  logic        dst_wr;
  logic        taken;

  assign imm32  = {{16{ins.immediate[15]}}, ins.immediate};
  assign opa    = (ins.source_a_reg == srie_pkg::IMM_SEL) ? imm32 : rd_a;
  assign opb    = (ins.source_b_reg == srie_pkg::IMM_SEL) ? imm32 : rd_b;
  assign dst_wr = (ins.dest_reg != 3'd0) && (ins.dest_reg != srie_pkg::IMM_SEL);

  always_comb begin
    case (ins.opcode)
      srie_pkg::OP_ADD: alu = opa + opb;
      srie_pkg::OP_SUB: alu = opa - opb;
      srie_pkg::OP_LSF: alu = opa << opb[4:0];
      srie_pkg::OP_RSF: alu = 32'($signed(opa) >>> opb[4:0]);
      srie_pkg::OP_AND: alu = opa & opb;
      srie_pkg::OP_OR:  alu = opa | opb;
      default:          alu = opa ^ opb;
    endcase
  end

  always_comb begin
    case (ins.opcode)
      srie_pkg::OP_JLT: taken = $signed(opa) < $signed(opb);
      srie_pkg::OP_JLE: taken = $signed(opa) <= $signed(opb);
      srie_pkg::OP_JEQ: taken = opa == opb;
      default:          taken = opa != opb;
    endcase
  end

  always_comb begin
    res     = '0;
    res.npc = pc + 16'd1;
    case (ins.opcode)
      srie_pkg::OP_ADD, srie_pkg::OP_SUB, srie_pkg::OP_LSF, srie_pkg::OP_RSF,
      srie_pkg::OP_AND, srie_pkg::OP_OR, srie_pkg::OP_XOR: begin
        res.a       = opa;
        res.b       = opb;
        res.wr_en   = dst_wr;
        res.wr_addr = ins.dest_reg;
        res.wr_data = alu;
      end
      srie_pkg::OP_LHI: begin
        // rd_a was read at the destination; keep its low half
        res.a       = {ins.immediate, 16'h0000};
        res.wr_en   = dst_wr;
        res.wr_addr = ins.dest_reg;
        res.wr_data = {ins.immediate, rd_a[15:0]};
      end
      srie_pkg::OP_LD: begin
        res.b      = opb;
        res.mem_re = opb < MEM_LIMIT;
        res.ld_wb  = (opb < MEM_LIMIT) && dst_wr;
      end
      srie_pkg::OP_ST: begin
        res.a      = opa;
        res.b      = opb;
        res.mem_we = opb < MEM_LIMIT;
      end
      srie_pkg::OP_JLT, srie_pkg::OP_JLE, srie_pkg::OP_JEQ, srie_pkg::OP_JNE: begin
        res.a = opa;
        res.b = opb;
        if (taken) begin
          res.wr_en   = 1'b1;
          res.wr_addr = srie_pkg::LINK_REG;
          res.wr_data = {16'h0000, pc};
          res.npc     = ins.immediate;
        end
      end
      srie_pkg::OP_JIN: begin
        res.a       = opa;
        res.wr_en   = 1'b1;
        res.wr_addr = srie_pkg::LINK_REG;
        res.wr_data = {16'h0000, pc};
        if (opa < MEM_LIMIT) begin
          res.npc = opa[15:0];
        end
      end
      srie_pkg::OP_HLT: begin
        res.npc    = pc;
        res.halted = 1'b1;
      end
      default: begin
        res.npc = pc + 16'd1;
      end
    endcase
  end

endmodule

// ----- src/srie_dmem.sv -----
// Data memory with a single port, registered read and a clearing sweep after reset.
module srie_dmem #(
  parameter int MEM_WORDS = 4096,
  localparam int ADDR_W = $clog2(MEM_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srie_pkg::dmem_cmd_t  cmd,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [31:0]          wdata,
  output logic [31:0]          rdata,
  output logic                 busy
);

  logic [31:0]       mem [MEM_WORDS];
  logic [31:0]       rdata_r;
  logic              clear_r;
  logic [ADDR_W-1:0] clr_idx_r;
  logic [ADDR_W-1:0] clr_idx_nxt;

  assign clr_idx_nxt = clr_idx_r + ADDR_W'(1);

  // zero one word per cycle until the last word is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_idx_r <= '0;
    end else if (clear_r) begin
      clr_idx_r <= clr_idx_nxt;
      if (clr_idx_r == ADDR_W'(MEM_WORDS - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_r) begin
      mem[clr_idx_r] <= '0;
    end else if (cmd.we) begin
      mem[addr] <= wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clear_r;

endmodule

// ----- src/simple_risc_instruction_execute.sv -----
// Top level of the instruction execute block: operand stage, result stage, registers, PC.
//
//  channel | direction | ports                          | word contents
//  --------+-----------+--------------------------------+---------------------------------
//  in      | sink      | in_tvalid in_tready in_tdata   | one decoded instruction
//  out     | source    | out_tvalid out_tready out_tdata| one trace record, halt in tuser
//          |           | out_tuser                      |
//
// One instruction per cycle in steady state; a load that writes a register holds the
// next instruction in the operand stage while the loaded word, read from the registered
// memory port, goes back into the register file.
// After reset the data memory is swept to zero, one word a cycle, and in_tready stays
// low until the sweep is done. A stalled out channel holds its word in the
// result stage while the operand stage still takes one more instruction.
`include "simple_risc_instruction_execute_macros.svh"

module simple_risc_instruction_execute #(
  parameter int MEM_WORDS = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [4:0] opcode, [7:5] dest_reg, [10:8] source_a_reg, [13:11] source_b_reg,
  // [29:14] immediate, [31:30] zero
  input  logic [31:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] pc_of_instruction, [31:16] pc_next, [63:32] operand_a_value,
  // [95:64] operand_b_value
  output logic [95:0]  out_tdata,
  // [0] halted
  output logic         out_tuser
);

  localparam int ADDR_W = $clog2(MEM_WORDS);

  // instruction word and the register file
  srie_pkg::instr_t    in_ins;
  logic [2:0]          ra_in;
  logic [31:0]         rf_r [srie_pkg::NUM_REGS];

  // operand stage
  logic                s1_v_r;
  srie_pkg::instr_t    s1_ins_r;
  logic [2:0]          s1_ra_r;
  logic [2:0]          s1_rb_r;
  logic [31:0]         rd_a_r;
  logic [31:0]         rd_b_r;
  logic                s1_adv;
  logic                in_acc;

  // program counter
  logic [15:0]         pc_r;

  // result stage
  logic                s2_v_r;
  logic [15:0]         s2_pc_r;
  logic [15:0]         s2_npc_r;
  logic [31:0]         s2_a_r;
  logic [31:0]         s2_b_r;
  logic                s2_halt_r;
  logic                s2_ldok_r;
  logic [2:0]          s2_dst_r;
  logic                s2_wb_r;
  logic                s2_wb_nxt;
  logic                out_acc;

  // register write port
  logic                wp_en;
  logic [2:0]          wp_addr;
  logic [31:0]         wp_data;

  // execute and memory
  srie_pkg::exec_res_t ex;
  srie_pkg::dmem_cmd_t mem_cmd;
  logic [31:0]         mem_q;
  logic                mem_busy;

  assign in_ins = srie_pkg::instr_t'(in_tdata[29:0]);
  // LHI merges into its destination, so port A reads dest_reg for it
  assign ra_in  = (in_ins.opcode == srie_pkg::OP_LHI) ? in_ins.dest_reg : in_ins.source_a_reg;

  // advance when the result stage frees up and no load writeback owns the write port
  assign s1_adv    = s1_v_r && !s2_wb_r && (!s2_v_r || out_tready);
  assign in_tready = !mem_busy && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  srie_exec #(
    .MEM_WORDS (MEM_WORDS)
  ) u_exec (
    .ins  (s1_ins_r),
    .rd_a (rd_a_r),
    .rd_b (rd_b_r),
    .pc   (pc_r),
    .res  (ex)
  );

  assign mem_cmd.we = s1_adv && ex.mem_we;
  assign mem_cmd.re = s1_adv && ex.mem_re;

  srie_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .addr  (ex.b[ADDR_W-1:0]),
    .wdata (ex.a),
    .rdata (mem_q),
    .busy  (mem_busy)
  );

  // Single write port: load writeback wins, and then the operand stage never advances.
  assign wp_en   = s2_wb_r || (s1_adv && ex.wr_en);
  assign wp_addr = s2_wb_r ? s2_dst_r : ex.wr_addr;
  assign wp_data = s2_wb_r ? mem_q : ex.wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r <= '{default: '0};
    end else if (wp_en) begin
      rf_r[wp_addr] <= wp_data;
    end
  end

  // Read operands on accept with write-first bypass; refresh them in place if a
  // load writeback lands while the instruction waits here.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ins_r <= in_ins;
      s1_ra_r  <= ra_in;
      s1_rb_r  <= in_ins.source_b_reg;
      rd_a_r   <= (wp_en && wp_addr == ra_in) ? wp_data : rf_r[ra_in];
      rd_b_r   <= (wp_en && wp_addr == in_ins.source_b_reg) ? wp_data
                                                           : rf_r[in_ins.source_b_reg];
    end else if (s1_v_r && wp_en) begin
      if (wp_addr == s1_ra_r) begin
        rd_a_r <= wp_data;
      end
      if (wp_addr == s1_rb_r) begin
        rd_b_r <= wp_data;
      end
    end
  end

  assign s2_wb_nxt = s1_adv && ex.ld_wb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s2_wb_r <= 1'b0;
      pc_r    <= '0;
    end else begin
      s2_wb_r <= s2_wb_nxt;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
        pc_r   <= ex.npc;
      end else if (out_acc) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_pc_r   <= pc_r;
      s2_npc_r  <= ex.npc;
      s2_a_r    <= ex.a;
      s2_b_r    <= ex.b;
      s2_halt_r <= ex.halted;
      s2_ldok_r <= ex.mem_re;
      s2_dst_r  <= s1_ins_r.dest_reg;
    end
  end

  // memory read data stays put until the next load advances
  assign out_tvalid = s2_v_r;
  assign out_tdata  = {s2_b_r, (s2_ldok_r ? mem_q : s2_a_r), s2_npc_r, s2_pc_r};
  assign out_tuser  = s2_halt_r;

  `SRIE_ASSERT_NOW(a_wb_has_load, s2_wb_r, s2_v_r && s2_ldok_r)
  `SRIE_ASSERT_NEXT(a_pc_follows, s1_adv, pc_r == s2_npc_r)
  `SRIE_ASSERT_NOW(a_halt_holds_pc, out_tvalid && out_tuser, s2_npc_r == s2_pc_r)
  `SRIE_ASSERT_NOW(a_idle_while_clearing, mem_busy, !s1_v_r && !s2_wb_r && !mem_cmd.re)

endmodule

// ----- tb/simple_risc_instruction_execute_tb.sv -----
// Self-checking testbench for the instruction execute block: directed, random and stall tests.
module simple_risc_instruction_execute_tb;

  localparam int MEM_WORDS = 4096;
  // Give up far beyond the slowest legal run (memory sweep, stalls, gaps).
  localparam int CYCLE_LIMIT = 200000;
  // Let the pipeline settle at the end; a register-writing load adds a stall.
  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_PCT = 14;
  localparam int HOLD_OFF_CYCLES = 300;
  // Opcodes that the block does not decode.
  localparam logic [4:0] OP_UNUSED_LO = 5'd10;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;

  // One trace record as the block reports it.
  typedef struct {
    logic [15:0] pc;
    logic [15:0] npc;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        halted;
  } trace_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [4:0] opcode, [7:5] dest_reg, [10:8] source_a_reg, [13:11] source_b_reg,
  // [29:14] immediate, [31:30] zero
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [15:0] pc_of_instruction, [31:16] pc_next, [63:32] operand_a_value,
  // [95:64] operand_b_value
  logic [95:0] out_tdata;
  // [0] halted
  logic        out_tuser;

  // Machine state as the testbench expects it.
  logic [31:0] regs [srie_pkg::NUM_REGS];
  logic [31:0] dmem [MEM_WORDS];
  logic [15:0] cur_pc;

  trace_t pending_traces [$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     steady = 1'b0;     // no idling on either side while set
  int     hold_cycles = 0;   // receiver hold-off still to run

  simple_risc_instruction_execute #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------------

  // Source index IMM_SEL reads the sign-extended immediate instead of a register.
  function automatic logic [31:0] read_src(logic [2:0] idx, logic [31:0] imm32);
    return (idx == srie_pkg::IMM_SEL) ? imm32 : regs[idx];
  endfunction

  // Drop writes to the two hardwired registers.
  function automatic void write_reg(logic [2:0] idx, logic [31:0] value);
    if (idx > srie_pkg::IMM_SEL) regs[idx] = value;
  endfunction

  // Execute one instruction on the expected state and return its trace.
  function automatic trace_t run_instruction(srie_pkg::instr_t w);
    trace_t      t;
    logic [31:0] imm32;
    logic [31:0] res;
    bit          taken;
    imm32 = {{16{w.immediate[15]}}, w.immediate};
    t = '{pc: cur_pc, npc: cur_pc + 16'd1, op_a: '0, op_b: '0, halted: 1'b0};
    res = '0;
    taken = 1'b0;
    case (w.opcode)
      srie_pkg::OP_ADD, srie_pkg::OP_SUB, srie_pkg::OP_LSF, srie_pkg::OP_RSF,
      srie_pkg::OP_AND, srie_pkg::OP_OR, srie_pkg::OP_XOR: begin
        t.op_a = read_src(w.source_a_reg, imm32);
        t.op_b = read_src(w.source_b_reg, imm32);
        case (w.opcode)
          srie_pkg::OP_ADD: res = t.op_a + t.op_b;
          srie_pkg::OP_SUB: res = t.op_a - t.op_b;
          srie_pkg::OP_LSF: res = t.op_a << t.op_b[4:0];
          srie_pkg::OP_RSF: res = $signed(t.op_a) >>> t.op_b[4:0];
          srie_pkg::OP_AND: res = t.op_a & t.op_b;
          srie_pkg::OP_OR:  res = t.op_a | t.op_b;
          default: res = t.op_a ^ t.op_b;
        endcase
        write_reg(w.dest_reg, res);
      end
      srie_pkg::OP_LHI: begin
        // Keep the destination's own low half.
        t.op_a = {w.immediate, 16'h0000};
        write_reg(w.dest_reg, t.op_a | {16'h0000, regs[w.dest_reg][15:0]});
      end
      srie_pkg::OP_LD: begin
        t.op_b = read_src(w.source_b_reg, imm32);
        if (t.op_b < MEM_WORDS) begin
          t.op_a = dmem[t.op_b];
          write_reg(w.dest_reg, t.op_a);
        end
      end
      srie_pkg::OP_ST: begin
        t.op_a = read_src(w.source_a_reg, imm32);
        t.op_b = read_src(w.source_b_reg, imm32);
        if (t.op_b < MEM_WORDS) dmem[t.op_b] = t.op_a;
      end
      srie_pkg::OP_JLT, srie_pkg::OP_JLE, srie_pkg::OP_JEQ, srie_pkg::OP_JNE: begin
        t.op_a = read_src(w.source_a_reg, imm32);
        t.op_b = read_src(w.source_b_reg, imm32);
        case (w.opcode)
          srie_pkg::OP_JLT: taken = $signed(t.op_a) < $signed(t.op_b);
          srie_pkg::OP_JLE: taken = $signed(t.op_a) <= $signed(t.op_b);
          srie_pkg::OP_JEQ: taken = t.op_a == t.op_b;
          default: taken = t.op_a != t.op_b;
        endcase
        if (taken) begin
          regs[srie_pkg::LINK_REG] = {16'h0000, cur_pc};
          t.npc = w.immediate;
        end
      end
      srie_pkg::OP_JIN: begin
        // Read the target before the link write, so a jump through R7 uses its old value.
        t.op_a = read_src(w.source_a_reg, imm32);
        regs[srie_pkg::LINK_REG] = {16'h0000, cur_pc};
        if (t.op_a < MEM_WORDS) t.npc = t.op_a[15:0];
      end
      srie_pkg::OP_HLT: begin
        t.npc = cur_pc;
        t.halted = 1'b1;
      end
      default: ;
    endcase
    cur_pc = t.npc;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic srie_pkg::instr_t encode(logic [4:0] op, logic [2:0] dst,
                                              logic [2:0] src_a, logic [2:0] src_b,
                                              logic [15:0] imm);
    srie_pkg::instr_t w;
    w.opcode = op;
    w.dest_reg = dst;
    w.source_a_reg = src_a;
    w.source_b_reg = src_b;
    w.immediate = imm;
    return w;
  endfunction

  // Offer one word, idling first at random; leave tvalid high for the next word.
  task automatic send_instr(input srie_pkg::instr_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, w};
    do @(posedge clk); while (!in_tready);
    pending_traces.push_back(run_instruction(w));
  endtask

  // Drop the input and hold it until every expected trace has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_traces.size() != 0) @(posedge clk);
  endtask

  // Favor addresses in the low words and at the memory edge, shift amounts and extremes.
  function automatic logic [15:0] pick_imm();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 16'($urandom_range(15));
    if (roll < 50) return 16'(MEM_WORDS - 2 + $urandom_range(3));
    if (roll < 58) return 16'(-$urandom_range(1, 3));
    if (roll < 64) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    return 16'($urandom());
  endfunction

  // Weight loads and stores up; a few picks are any 5-bit value, unused codes among them.
  function automatic logic [4:0] pick_opcode();
    case ($urandom_range(19))
      0: return srie_pkg::OP_ADD;
      1: return srie_pkg::OP_SUB;
      2: return srie_pkg::OP_LSF;
      3: return srie_pkg::OP_RSF;
      4: return srie_pkg::OP_AND;
      5: return srie_pkg::OP_OR;
      6: return srie_pkg::OP_XOR;
      7: return srie_pkg::OP_LHI;
      8, 16: return srie_pkg::OP_LD;
      9, 17: return srie_pkg::OP_ST;
      10: return srie_pkg::OP_JLT;
      11: return srie_pkg::OP_JLE;
      12: return srie_pkg::OP_JEQ;
      13: return srie_pkg::OP_JNE;
      14: return srie_pkg::OP_JIN;
      15: return srie_pkg::OP_HLT;
      default: return 5'($urandom());
    endcase
  endfunction

  task automatic send_random_instr();
    srie_pkg::instr_t w;
    w = encode(pick_opcode(), 3'($urandom()), 3'($urandom()), 3'($urandom()), pick_imm());
    // Aim most memory accesses at words that exist so loads see earlier stores.
    if ((w.opcode == srie_pkg::OP_LD || w.opcode == srie_pkg::OP_ST) &&
        $urandom_range(99) < 60)
      w.source_b_reg = srie_pkg::IMM_SEL;
    if (w.opcode == srie_pkg::OP_JIN && $urandom_range(1)) w.source_a_reg = srie_pkg::IMM_SEL;
    send_instr(w);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    // Immediate extremes on both sources, writes to R0 and R1 dropped.
    send_instr(encode(srie_pkg::OP_ADD, 3'd2, srie_pkg::IMM_SEL, srie_pkg::IMM_SEL, 16'h8000));
    send_instr(encode(srie_pkg::OP_ADD, 3'd3, srie_pkg::IMM_SEL, srie_pkg::IMM_SEL, 16'h7FFF));
    send_instr(encode(srie_pkg::OP_ADD, 3'd0, 3'd2, 3'd3, 16'h0000));
    send_instr(encode(srie_pkg::OP_ADD, srie_pkg::IMM_SEL, srie_pkg::IMM_SEL,
                      srie_pkg::IMM_SEL, 16'h1234));
    send_instr(encode(srie_pkg::OP_SUB, 3'd4, 3'd0, 3'd3, 16'h0000));
    // Shift amount takes only its low five bits; right shift keeps the sign.
    send_instr(encode(srie_pkg::OP_LSF, 3'd5, 3'd3, srie_pkg::IMM_SEL, 16'd33));
    send_instr(encode(srie_pkg::OP_RSF, 3'd6, 3'd2, srie_pkg::IMM_SEL, 16'd4));
    send_instr(encode(srie_pkg::OP_AND, 3'd2, 3'd2, 3'd3, 16'h0000));
    send_instr(encode(srie_pkg::OP_OR, 3'd3, 3'd1, 3'd6, 16'h00F0));
    send_instr(encode(srie_pkg::OP_XOR, 3'd4, 3'd4, srie_pkg::IMM_SEL, 16'hFFFF));
    // Load-high keeps the destination's low half.
    send_instr(encode(srie_pkg::OP_LHI, 3'd5, 3'd0, 3'd0, 16'h8001));
    // Store and load at the last word, one past it and at a negative address.
    send_instr(encode(srie_pkg::OP_ST, 3'd0, 3'd5, srie_pkg::IMM_SEL, 16'(MEM_WORDS - 1)));
    send_instr(encode(srie_pkg::OP_ST, 3'd0, 3'd4, srie_pkg::IMM_SEL, 16'(MEM_WORDS)));
    send_instr(encode(srie_pkg::OP_ST, 3'd0, 3'd4, srie_pkg::IMM_SEL, 16'hFFFF));
    send_instr(encode(srie_pkg::OP_LD, 3'd6, 3'd0, srie_pkg::IMM_SEL, 16'(MEM_WORDS - 1)));
    send_instr(encode(srie_pkg::OP_LD, 3'd6, 3'd0, srie_pkg::IMM_SEL, 16'(MEM_WORDS)));
    send_instr(encode(srie_pkg::OP_LD, 3'd2, 3'd0, 3'd4, 16'h0000));
    // Signed compares: taken and not taken.
    send_instr(encode(srie_pkg::OP_JLT, 3'd0, 3'd5, 3'd0, 16'd200));
    send_instr(encode(srie_pkg::OP_JLE, 3'd0, 3'd0, 3'd1, 16'd300));
    send_instr(encode(srie_pkg::OP_JEQ, 3'd0, 3'd6, 3'd0, 16'd400));
    send_instr(encode(srie_pkg::OP_JNE, 3'd0, 3'd0, 3'd0, 16'd500));
    // Jump to the top of the PC range, then let the increment wrap to zero.
    send_instr(encode(srie_pkg::OP_JEQ, 3'd0, srie_pkg::IMM_SEL, srie_pkg::IMM_SEL, 16'hFFFF));
    send_instr(encode(OP_UNUSED_LO, 3'd7, 3'd7, 3'd7, 16'h5555));
    // Indirect jump: in range, out of range, through R7 itself.
    send_instr(encode(srie_pkg::OP_JIN, 3'd0, srie_pkg::IMM_SEL, 3'd0, 16'd100));
    send_instr(encode(srie_pkg::OP_JIN, 3'd0, srie_pkg::IMM_SEL, 3'd0, 16'(MEM_WORDS)));
    send_instr(encode(srie_pkg::OP_JIN, 3'd0, srie_pkg::LINK_REG, 3'd0, 16'h0000));
    send_instr(encode(srie_pkg::OP_HLT, 3'd7, 3'd7, 3'd7, 16'hAAAA));
    send_instr(encode(srie_pkg::OP_HLT, 3'd0, 3'd0, 3'd0, 16'h0000));
    send_instr(encode(OP_UNUSED_HI, 3'd7, 3'd7, 3'd7, 16'hFFFF));
  endtask

  task automatic test_random_program(input int count, input bit no_idle);
    steady = no_idle;
    repeat (count) send_random_instr();
    steady = 1'b0;
  endtask

  // Stall the receiver for a long stretch while words keep coming, so the input backs up.
  task automatic test_output_hold_off();
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (60) send_random_instr();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %h got %h", what, want, got);
  endtask

  // Compare each trace word with the oldest expectation.
  always @(posedge clk) begin
    trace_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_traces.size() == 0) begin
        flag_error("unexpected word", '0, out_tdata[31:0]);
      end else begin
        want = pending_traces.pop_front();
        if (out_tdata[15:0] !== want.pc) flag_error("pc", want.pc, out_tdata[15:0]);
        if (out_tdata[31:16] !== want.npc) flag_error("pc_next", want.npc, out_tdata[31:16]);
        if (out_tdata[63:32] !== want.op_a) flag_error("operand_a", want.op_a, out_tdata[63:32]);
        if (out_tdata[95:64] !== want.op_b) flag_error("operand_b", want.op_b, out_tdata[95:64]);
        if (out_tuser !== want.halted) flag_error("halted", want.halted, out_tuser);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simple_risc_instruction_execute_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < srie_pkg::NUM_REGS; i++) regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
    cur_pc = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // The memory sweep after reset keeps in_tready low; send_instr waits it out.
    test_directed_cases();
    wait_for_results();
    test_random_program(300, 1'b0);
    test_random_program(200, 1'b1);
    wait_for_results();
    test_output_hold_off();
    test_random_program(250, 1'b0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_traces.size() != 0) flag_error("words never returned", '0, '0);
    if (mismatches == 0) begin
      $display("simple_risc_instruction_execute_tb OK");
    end else begin
      $display("simple_risc_instruction_execute_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/srie_pkg.sv
src/srie_exec.sv
src/srie_dmem.sv
src/simple_risc_instruction_execute.sv
tb/simple_risc_instruction_execute_tb.sv
